>>> hw/rtl/fpm_pkg.sv
// Shared types and constants for the fp32 multiplier
`default_nettype none
package fpm_pkg;
  localparam logic [2:0] RM_RNE = 3'd0;
  localparam logic [2:0] RM_RTZ = 3'd1;
  localparam logic [2:0] RM_RDN = 3'd2;
  localparam logic [2:0] RM_RUP = 3'd3;
  localparam logic [2:0] RM_RMM = 3'd4;
  localparam logic [31:0] QNAN_DEF = 32'hffc00000;
  localparam logic [31:0] INF_BITS = 32'h7f800000;
  localparam logic [31:0] MAX_FIN  = 32'h7f7fffff;
  localparam logic [31:0] QUIET_BIT = 32'h00400000;

  // classified operation handed from front to back
  typedef struct packed {
    logic        special;
    logic [31:0] special_res;
    logic        sign;
    logic [2:0]  rm;
    logic [23:0] ma;
    logic [23:0] mb;
    logic signed [10:0] exp_sum;
  } fpm_op_t;
endpackage
`default_nettype wire

>>> hw/rtl/fp32_multiplier.sv
// Top level of the binary32 multiplier
// Usage:
//  Input queue side: drive a_operand_i, b_operand_i, rounding_mode_i and
//  push; a word is taken at a clock edge with push high and full low.
//  Result queue side: while empty is low, product_o holds the oldest
//  product; it is taken at an edge with pop high.
//  The front stage decodes operands and resolves NaN, infinity and zero;
//  the back end multiplies the 24-bit significands in one stage and
//  normalizes, rounds and packs in the next.
//  A word passes the front, multiply and result registers on its way out.
//  Throughput: one word per cycle while the result queue is popped or empty,
//  set by the single 24x24 multiplier stage. When pop stays low the
//  pipeline fills (up to three words) and then full rises; nothing is lost.
//  Reset (rst_ni low, asynchronous) empties all stages.
`default_nettype none
module fp32_multiplier (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire logic [31:0] a_operand_i,
  input  wire logic [31:0] b_operand_i,
  input  wire logic [2:0]  rounding_mode_i,
  output logic      empty,
  input  wire logic pop,
  output logic [31:0] product_o
);
  logic fv, br;
  fpm_pkg::fpm_op_t op;

  fpm_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .a_operand_i, .b_operand_i, .rounding_mode_i,
    .valid_o(fv), .ready_i(br), .op_o(op)
  );

  fpm_back u_back (
    .clk_i, .rst_ni, .valid_i(fv), .ready_o(br), .op_i(op),
    .empty_o(empty), .pop_i(pop), .product_o
  );
endmodule
`default_nettype wire

>>> hw/rtl/fpm_front.sv
// Front end: decodes operands, resolves special cases, registers one word
`default_nettype none
module fpm_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      full_o,
  input  wire logic [31:0] a_operand_i,
  input  wire logic [31:0] b_operand_i,
  input  wire logic [2:0]  rounding_mode_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output fpm_pkg::fpm_op_t op_o
);
  logic valid_q, valid_d;
  fpm_pkg::fpm_op_t op_q, op_d;
  logic [7:0] ea, eb;
  logic [22:0] fa, fb;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;

  assign full_o = valid_q && !ready_i;
  assign valid_o = valid_q;
  assign op_o = op_q;

  // classification
  always_comb begin
    ea = a_operand_i[30:23];
    eb = b_operand_i[30:23];
    fa = a_operand_i[22:0];
    fb = b_operand_i[22:0];
    sgn = a_operand_i[31] ^ b_operand_i[31];
    a_nan = (ea == 8'hff) && (fa != '0);
    b_nan = (eb == 8'hff) && (fb != '0);
    a_inf = (ea == 8'hff) && (fa == '0);
    b_inf = (eb == 8'hff) && (fb == '0);
    a_zero = (ea == '0) && (fa == '0);
    b_zero = (eb == '0) && (fb == '0);
    op_d.sign = sgn;
    op_d.rm = rounding_mode_i;
    op_d.ma = {ea != '0, fa};
    op_d.mb = {eb != '0, fb};
    op_d.exp_sum = $signed({3'b0, (ea == '0) ? 8'd1 : ea})
                 + $signed({3'b0, (eb == '0) ? 8'd1 : eb}) - 11'sd127;
    op_d.special = 1'b1;
    if (a_nan)       op_d.special_res = a_operand_i | fpm_pkg::QUIET_BIT;
    else if (b_nan)  op_d.special_res = b_operand_i | fpm_pkg::QUIET_BIT;
    else if (a_inf || b_inf)
      op_d.special_res = (a_zero || b_zero) ? fpm_pkg::QNAN_DEF
                                            : (fpm_pkg::INF_BITS | {sgn, 31'b0});
    else if (a_zero || b_zero) op_d.special_res = {sgn, 31'b0};
    else begin
      op_d.special = 1'b0;
      op_d.special_res = '0;
    end
    valid_d = valid_q;
    if (ready_i) valid_d = 1'b0;
    if (push_i && !full_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) op_q <= op_d;
  end
endmodule
`default_nettype wire

>>> hw/rtl/fpm_back.sv
// Back end: multiply stage, then normalize/round stage into an output register
`default_nettype none
module fpm_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  fpm_pkg::fpm_op_t op_i,
  output logic      empty_o,
  input  wire logic pop_i,
  output logic [31:0] product_o
);
  // stage 1: multiply
  logic v1_q, v2_q, adv1, adv2;
  logic [47:0] p_q;
  logic special_q, sign_q;
  logic [31:0] sres_q;
  logic [2:0] rm_q;
  logic signed [10:0] esum_q;
  logic [31:0] res_q, res_d;

  assign adv2 = !v2_q || pop_i;
  assign adv1 = !v1_q || adv2;
  assign ready_o = adv1;
  assign empty_o = !v2_q;
  assign product_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      p_q <= op_i.ma * op_i.mb;
      special_q <= op_i.special;
      sres_q <= op_i.special_res;
      sign_q <= op_i.sign;
      rm_q <= op_i.rm;
      esum_q <= op_i.exp_sum;
    end
    if (adv2 && v1_q) res_q <= res_d;
  end

  // stage 2: normalize, round, pack
  logic [5:0] lzc;
  logic signed [11:0] ideal, rs, ex;
  logic [47:0] sh;
  logic lost, g, r, s, up, to_inf;
  logic [23:0] mant;
  logic [24:0] minc;
  always_comb begin
    lzc = 6'd47;
    for (int i = 0; i < 48; i++)
      if (p_q[i]) lzc = 6'(47 - i);
    ideal = 12'(esum_q) + 12'sd1 - $signed({6'b0, lzc});
    rs = 12'sd1 - 12'(esum_q);
    lost = 1'b0;
    sh = p_q;
    if (ideal >= 12'sd1) begin
      ex = ideal;
      if (lzc == '0) begin
        sh = p_q >> 1;
        lost = p_q[0];
      end else sh = p_q << (lzc - 6'd1);
    end else begin
      ex = '0;
      if (rs > 12'sd47) begin
        sh = '0;
        lost = p_q != '0;
      end else if (rs > 12'sd0) begin
        sh = p_q >> rs[5:0];
        lost = (p_q & ((48'd1 << rs[5:0]) - 48'd1)) != '0;
      end else if (rs < 12'sd0) sh = p_q << 6'(-rs);
    end
    mant = sh[46:23];
    g = sh[22];
    r = sh[21];
    s = (sh[20:0] != '0) || lost;
    case (rm_q)
      fpm_pkg::RM_RNE: up = g && (mant[0] || r || s);
      fpm_pkg::RM_RDN: up = sign_q && (g || r || s);
      fpm_pkg::RM_RUP: up = !sign_q && (g || r || s);
      fpm_pkg::RM_RMM: up = g;
      default:         up = 1'b0;
    endcase
    minc = {1'b0, mant} + 25'd1;
    if (up) begin
      if (minc[24]) begin
        mant = 24'h800000;
        ex = ex + 12'sd1;
      end else begin
        mant = minc[23:0];
        if (ex == '0 && mant[23]) ex = 12'sd1;
      end
    end
    case (rm_q)
      fpm_pkg::RM_RTZ: to_inf = 1'b0;
      fpm_pkg::RM_RDN: to_inf = sign_q;
      fpm_pkg::RM_RUP: to_inf = !sign_q;
      default:         to_inf = 1'b1;
    endcase
    if (special_q) res_d = sres_q;
    else if (ex >= 12'sd255)
      res_d = {sign_q, to_inf ? fpm_pkg::INF_BITS[30:0] : fpm_pkg::MAX_FIN[30:0]};
    else res_d = {sign_q, ex[7:0], mant[22:0]};
  end
endmodule
`default_nettype wire
